>>> rtl/ppg_hrd_pkg.sv
package ppg_hrd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;

  localparam int AC_SHIFT = 17 - FRACTION_BITS;
  localparam int BASE_W   = SAMPLE_BITS + 16;
  localparam int ENV_W    = SAMPLE_BITS + FRACTION_BITS;
  localparam int AC_W     = ENV_W + 2;
  localparam int SUM_W    = BASE_W + 2;

  localparam int MAC_A_W = 16;
  localparam int MAC_B_W = (BASE_W > ENV_W + 1) ? BASE_W : ENV_W + 1;
  localparam int ACC_W   = MAC_A_W + MAC_B_W + 1;

  localparam int NUM_W = 24;
  localparam int DIV_W = 16;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MAC_A_W-1:0] DC_KEEP     = 16'd65208;
  localparam logic [MAC_A_W-1:0] DC_TAKE     = 16'd328;
  localparam logic [MAC_A_W-1:0] SMOOTH_KEEP = 16'd58982;
  localparam logic [MAC_A_W-1:0] SMOOTH_TAKE = 16'd6554;
  localparam logic [NUM_W-1:0]   BPM_NUMERATOR = 24'd15360000;

  localparam logic [7:0]  TF_RESET      = 8'd128;
  localparam logic [15:0] MIN_INT_RESET = 16'd300;
  localparam logic [15:0] MAX_INT_RESET = 16'd2000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_THR_FRAC = 2'd0,
    CFG_MIN_INT  = 2'd1,
    CFG_MAX_INT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RB_KEEP,
    S_RB_TAKE,
    S_IB_KEEP,
    S_IB_TAKE,
    S_IB_CAP,
    S_AC,
    S_ENV_TAKE,
    S_ENV_CAP,
    S_THR,
    S_BEAT,
    S_CHECK,
    S_DIV,
    S_RATE_KEEP,
    S_RATE_TAKE,
    S_RATE_CAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               en;
    logic               clr;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
  } mac_cmd_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> rtl/ppg_hrd_mac.sv
module ppg_hrd_mac (
  input  logic                           clk,
  input  ppg_hrd_pkg::mac_cmd_t          cmd,
  output logic [ppg_hrd_pkg::ACC_W-1:0]  acc
);
  import ppg_hrd_pkg::*;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [MAC_A_W+MAC_B_W-1:0] prod;

  assign prod = cmd.a * cmd.b;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.en) begin
      acc_nxt = (cmd.clr ? '0 : acc_r) + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

>>> rtl/ppg_hrd_div.sv
module ppg_hrd_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppg_hrd_pkg::div_req_t req,
  output ppg_hrd_pkg::div_rsp_t rsp
);
  import ppg_hrd_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, req.den};
  assign rem_sub = rem_sh - {1'b0, req.den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      quo_nxt  = req.num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      rem_nxt = fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> rtl/ppg_heart_rate_detector.sv
// channel   dir  width  contents
// in_*      in   64     transaction = one red/infrared sample pair with timestamp
// out_*     out  56     transaction = beat flags, interval and smoothed rate
// cfg_*     in   16     register writes, index 0..2
// a result is registered after the sequencer's steps, seven of them on the shared
// multiply-accumulate unit, and the next item is accepted once it is back in idle;
// an accepted interval adds the 24-step radix-2 divider and three smoothing steps
// synchronous active-low reset restores carried filter state and register defaults
// in_tready is high only while the sequencer is idle; a held result in the
// output register stalls the next item only at its final step
module ppg_heart_rate_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // red_sample[15:0], infrared_sample[31:16], timestamp_ms[63:32]
  input  logic [ppg_hrd_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // beat_seen[0], interval_accepted[1], interval_ms[33:2], rate_bpm[49:34],
  // rate_valid[50], zero fill[55:51]
  output logic [ppg_hrd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                  cfg_we,
  input  logic [ppg_hrd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ppg_hrd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ppg_hrd_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]  tf_r;
  logic [15:0] min_r;
  logic [15:0] max_r;

  logic [SAMPLE_BITS-1:0] red_r, red_nxt;
  logic [SAMPLE_BITS-1:0] ir_r, ir_nxt;
  logic [31:0]            ts_r, ts_nxt;

  logic [BASE_W-1:0]       rb_r, rb_nxt;
  logic [BASE_W-1:0]       ib_r, ib_nxt;
  logic signed [SUM_W-1:0] rx_r, rx_nxt;
  logic signed [AC_W-1:0]  ac_r, ac_nxt;
  logic signed [AC_W-1:0]  prev_ac_r, prev_ac_nxt;
  logic [ENV_W-1:0]        env_r, env_nxt;
  logic [31:0]             pbt_r, pbt_nxt;
  logic                    have_r, have_nxt;
  logic [15:0]             rate_r, rate_nxt;
  logic                    known_r, known_nxt;

  logic        beat_r, beat_nxt;
  logic        chk_r, chk_nxt;
  logic        ok_r, ok_nxt;
  logic [31:0] interval_r, interval_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  mac_cmd_t         mac_cmd;
  logic [ACC_W-1:0] mac_acc;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic [ACC_W-1:0]          acc_rnd;
  logic [ACC_W-17:0]         rnd_val;
  logic [BASE_W-1:0]         red_sh;
  logic [BASE_W-1:0]         ir_sh;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_sh;
  logic [AC_W-1:0]           mag;
  logic [ENV_W-1:0]          thr;
  logic signed [AC_W-1:0]    thr_x;
  logic                      beat;
  logic [15:0]               bpm_sat;
  logic                      in_limits;

  ppg_hrd_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .acc (mac_acc)
  );

  ppg_hrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign acc_rnd = mac_acc + ACC_W'(32768);
  assign rnd_val = acc_rnd[ACC_W-1:16];

  assign red_sh = {red_r, 16'b0};
  assign ir_sh  = {ir_r, 16'b0};

  assign sum = rx_r + $signed({2'b0, ir_sh}) - $signed({2'b0, ib_r})
             + $signed(SUM_W'(1) << (AC_SHIFT - 1));
  assign sum_sh = sum >>> AC_SHIFT;

  assign mag   = ac_r[AC_W-1] ? AC_W'(-ac_r) : AC_W'(ac_r);
  assign thr   = mac_acc[ENV_W+7:8];
  assign thr_x = $signed({{(AC_W-ENV_W){1'b0}}, thr});
  assign beat  = (prev_ac_r < thr_x) && (ac_r >= thr_x);

  assign bpm_sat = (|div_rsp.quo[NUM_W-1:DIV_W]) ? 16'hFFFF : div_rsp.quo[DIV_W-1:0];

  assign in_limits = (interval_r != 32'd0) && (interval_r >= {16'b0, min_r})
                   && (interval_r <= {16'b0, max_r});

  assign div_req.num = BPM_NUMERATOR + NUM_W'(interval_r[DIV_W-1:1]);
  assign div_req.den = interval_r[DIV_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    red_nxt       = red_r;
    ir_nxt        = ir_r;
    ts_nxt        = ts_r;
    rb_nxt        = rb_r;
    ib_nxt        = ib_r;
    rx_nxt        = rx_r;
    ac_nxt        = ac_r;
    prev_ac_nxt   = prev_ac_r;
    env_nxt       = env_r;
    pbt_nxt       = pbt_r;
    have_nxt      = have_r;
    rate_nxt      = rate_r;
    known_nxt     = known_r;
    beat_nxt      = beat_r;
    chk_nxt       = chk_r;
    ok_nxt        = ok_r;
    interval_nxt  = interval_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    mac_cmd       = '0;
    div_req.start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          red_nxt   = SAMPLE_BITS'(in_tdata[15:0]);
          ir_nxt    = SAMPLE_BITS'(in_tdata[31:16]);
          ts_nxt    = in_tdata[63:32];
          ok_nxt    = 1'b0;
          state_nxt = S_RB_KEEP;
        end
      end
      S_RB_KEEP: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b1, a: DC_KEEP, b: MAC_B_W'(rb_r)};
        state_nxt = S_RB_TAKE;
      end
      S_RB_TAKE: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b0, a: DC_TAKE, b: MAC_B_W'(red_sh)};
        state_nxt = S_IB_KEEP;
      end
      S_IB_KEEP: begin
        rb_nxt    = rnd_val[BASE_W-1:0];
        mac_cmd   = '{en: 1'b1, clr: 1'b1, a: DC_KEEP, b: MAC_B_W'(ib_r)};
        state_nxt = S_IB_TAKE;
      end
      S_IB_TAKE: begin
        rx_nxt    = $signed({2'b0, red_sh}) - $signed({2'b0, rb_r});
        mac_cmd   = '{en: 1'b1, clr: 1'b0, a: DC_TAKE, b: MAC_B_W'(ir_sh)};
        state_nxt = S_IB_CAP;
      end
      S_IB_CAP: begin
        ib_nxt    = rnd_val[BASE_W-1:0];
        state_nxt = S_AC;
      end
      S_AC: begin
        ac_nxt    = AC_W'(sum_sh);
        mac_cmd   = '{en: 1'b1, clr: 1'b1, a: SMOOTH_KEEP, b: MAC_B_W'(env_r)};
        state_nxt = S_ENV_TAKE;
      end
      S_ENV_TAKE: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b0, a: SMOOTH_TAKE, b: MAC_B_W'(mag[AC_W-2:0])};
        state_nxt = S_ENV_CAP;
      end
      S_ENV_CAP: begin
        env_nxt   = rnd_val[ENV_W-1:0];
        state_nxt = S_THR;
      end
      S_THR: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b1, a: MAC_A_W'(tf_r), b: MAC_B_W'(env_r)};
        state_nxt = S_BEAT;
      end
      S_BEAT: begin
        beat_nxt     = beat;
        prev_ac_nxt  = ac_r;
        chk_nxt      = beat && have_r;
        interval_nxt = (beat && have_r) ? ts_r - pbt_r : 32'd0;
        if (beat) begin
          pbt_nxt  = ts_r;
          have_nxt = 1'b1;
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (chk_r && in_limits) begin
          ok_nxt        = 1'b1;
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_RATE_KEEP;
        end
      end
      S_RATE_KEEP: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b1, a: SMOOTH_KEEP, b: MAC_B_W'(rate_r)};
        state_nxt = S_RATE_TAKE;
      end
      S_RATE_TAKE: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b0, a: SMOOTH_TAKE, b: MAC_B_W'(bpm_sat)};
        state_nxt = S_RATE_CAP;
      end
      S_RATE_CAP: begin
        rate_nxt  = rnd_val[15:0];
        known_nxt = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'b0, known_r, rate_r, interval_r, ok_r, beat_r};
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rb_r         <= '0;
      ib_r         <= '0;
      env_r        <= '0;
      prev_ac_r    <= '0;
      pbt_r        <= '0;
      have_r       <= 1'b0;
      rate_r       <= '0;
      known_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rb_r         <= rb_nxt;
      ib_r         <= ib_nxt;
      env_r        <= env_nxt;
      prev_ac_r    <= prev_ac_nxt;
      pbt_r        <= pbt_nxt;
      have_r       <= have_nxt;
      rate_r       <= rate_nxt;
      known_r      <= known_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    red_r       <= red_nxt;
    ir_r        <= ir_nxt;
    ts_r        <= ts_nxt;
    rx_r        <= rx_nxt;
    ac_r        <= ac_nxt;
    beat_r      <= beat_nxt;
    chk_r       <= chk_nxt;
    ok_r        <= ok_nxt;
    interval_r  <= interval_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tf_r  <= TF_RESET;
      min_r <= MIN_INT_RESET;
      max_r <= MAX_INT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_THR_FRAC: tf_r  <= cfg_wdata[7:0];
        CFG_MIN_INT:  min_r <= cfg_wdata;
        CFG_MAX_INT:  max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  a_accept_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0] && out_tdata[50])
    else $error("interval accepted without beat or rate");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

endmodule
